// File: sv/pcbb_pkg.sv
// ----------------------------------------------------------------------------
// pcbb_pkg
// Shared types, constants and helpers for the prefix-compressed block builder.
// ----------------------------------------------------------------------------
package pcbb_pkg;

	localparam int MAX_KEY_LEN  = 256;
	localparam int KEY_AW       = $clog2(MAX_KEY_LEN);
	localparam int MAX_RESTARTS = 32;
	localparam int RST_AW       = $clog2(MAX_RESTARTS);
	localparam int CNT_W        = 6;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

	localparam logic [7:0] RI_RESET = 8'd16;

	localparam logic [1:0] OP_KEY = 2'd0;
	localparam logic [1:0] OP_VAL = 2'd1;
	localparam logic [1:0] OP_FIN = 2'd2;

	typedef enum logic [1:0] {
		CMD_HDR  = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_FIN  = 2'd2
	} cmd_kind_t;

	// One work unit from the front end to the emitter
	typedef struct packed {
		cmd_kind_t          kind;
		logic               rst_we;
		logic [RST_AW-1:0]  rst_idx;
		logic [31:0]        rst_off;
		logic [8:0]         shared_len;
		logic [8:0]         unshared_len;
		logic [15:0]        value_len;
		logic               has_byte;
		logic [7:0]         data;
		logic               ovf;
		logic [CNT_W-1:0]   cnt;
	} cmd_t;

	function automatic logic [1:0] varlen9(input logic [8:0] v);
		return (v >= 9'd128) ? 2'd2 : 2'd1;
	endfunction

	function automatic logic [1:0] varlen16(input logic [15:0] v);
		if (v >= 16'd16384)
			return 2'd3;
		else if (v >= 16'd128)
			return 2'd2;
		else
			return 2'd1;
	endfunction

endpackage

// File: sv/pcbb_front.sv
// ----------------------------------------------------------------------------
// pcbb_front
// Accepts key/value/finish items, tracks the shared prefix against the
// stored previous key and issues header, byte and trailer commands.
// ----------------------------------------------------------------------------
module pcbb_front import pcbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  data,
	input  logic [8:0]  key_len,
	input  logic [15:0] value_len,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        fifo_full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [7:0]        ri_q;
	logic [8:0]        pkl_q, pkl_d;
	logic [7:0]        ec_q, ec_d;
	logic [KEY_AW-1:0] kp_q, kp_d;
	logic              sm_q, sm_d;
	logic [CNT_W-1:0]  rc_q, rc_d;
	logic [31:0]       boff_q, boff_d;

	logic [7:0]        pk_mem [MAX_KEY_LEN];
	logic [7:0]        pk_rd_q;
	logic              pk_we;

	logic       acc;
	logic [8:0] kl, p9, p1;
	logic       at_end, first, restart, sm_eff, match, ovf;
	logic [3:0] hdr_bytes;

	assign acc      = in_valid & ~fifo_full;
	assign in_stall = fifo_full;

	always_comb begin
		if (key_len == 9'd0)
			kl = 9'd1;
		else if (key_len > 9'(MAX_KEY_LEN))
			kl = 9'(MAX_KEY_LEN);
		else
			kl = key_len;
	end

	assign p9      = 9'(kp_q);
	assign p1      = p9 + 9'd1;
	assign at_end  = (p1 >= kl);
	assign first   = (kp_q == '0);
	assign restart = first && (ec_q >= ri_q);
	assign sm_eff  = first ? 1'b1 : sm_q;
	assign match   = (p9 < pkl_q) && (pk_rd_q == data);
	assign ovf     = (rc_q >= CNT_W'(MAX_RESTARTS));

	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		push_cmd.kind = CMD_BYTE;
		pk_we    = 1'b0;
		pkl_d    = pkl_q;
		ec_d     = ec_q;
		kp_d     = kp_q;
		sm_d     = sm_q;
		rc_d     = rc_q;
		boff_d   = boff_q;
		if (acc) begin
			case (op)
				OP_KEY: begin
					pk_we = 1'b1;
					sm_d  = sm_eff;
					if (first)
						ec_d = restart ? 8'd1 : ec_q + 8'd1;
					push_cmd.value_len = value_len;
					push_cmd.data      = data;
					if (restart) begin
						push                  = 1'b1;
						push_cmd.kind         = CMD_HDR;
						push_cmd.shared_len   = 9'd0;
						push_cmd.unshared_len = kl;
						push_cmd.has_byte     = 1'b1;
						push_cmd.ovf          = ovf;
						push_cmd.rst_we       = ~ovf;
						push_cmd.rst_idx      = rc_q[RST_AW-1:0];
						push_cmd.rst_off      = boff_q;
						if (!ovf)
							rc_d = rc_q + CNT_W'(1);
						sm_d = 1'b0;
					end else if (sm_eff) begin
						if (!match) begin
							push                  = 1'b1;
							push_cmd.kind         = CMD_HDR;
							push_cmd.shared_len   = p9;
							push_cmd.unshared_len = (kl > p9) ? kl - p9 : 9'd0;
							push_cmd.has_byte     = 1'b1;
							sm_d                  = 1'b0;
						end else if (at_end) begin
							push                  = 1'b1;
							push_cmd.kind         = CMD_HDR;
							push_cmd.shared_len   = p1;
							push_cmd.unshared_len = (kl > p1) ? kl - p1 : 9'd0;
							push_cmd.has_byte     = 1'b0;
						end
					end else begin
						push = 1'b1;
					end
					if (at_end) begin
						pkl_d = p1;
						kp_d  = '0;
						sm_d  = 1'b1;
					end else begin
						kp_d = kp_q + KEY_AW'(1);
					end
				end
				OP_VAL: begin
					if (kp_q != '0) begin
						pkl_d = p9;
						kp_d  = '0;
						sm_d  = 1'b1;
					end
					push          = 1'b1;
					push_cmd.data = data;
				end
				OP_FIN: begin
					push          = 1'b1;
					push_cmd.kind = CMD_FIN;
					push_cmd.cnt  = rc_q;
					rc_d          = CNT_W'(1);
					pkl_d         = 9'd0;
					ec_d          = 8'd0;
					kp_d          = '0;
					sm_d          = 1'b1;
					boff_d        = 32'd0;
				end
				default: ;
			endcase
			// advance the block offset by the bytes this command will emit
			if (push && push_cmd.kind == CMD_HDR)
				boff_d = boff_q + 32'(hdr_bytes);
			else if (push && push_cmd.kind == CMD_BYTE)
				boff_d = boff_q + 32'd1;
		end
	end

	assign hdr_bytes = 4'(varlen9(push_cmd.shared_len)) + 4'(varlen9(push_cmd.unshared_len))
		+ 4'(varlen16(push_cmd.value_len)) + 4'(push_cmd.has_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ri_q   <= RI_RESET;
			pkl_q  <= 9'd0;
			ec_q   <= 8'd0;
			kp_q   <= '0;
			sm_q   <= 1'b1;
			rc_q   <= CNT_W'(1);
			boff_q <= 32'd0;
		end else begin
			if (cfg_wr_en)
				ri_q <= cfg_wr_data;
			pkl_q  <= pkl_d;
			ec_q   <= ec_d;
			kp_q   <= kp_d;
			sm_q   <= sm_d;
			rc_q   <= rc_d;
			boff_q <= boff_d;
		end
	end

	// prefetch the previous-key byte for the next key position
	always_ff @(posedge clk) begin
		if (pk_we)
			pk_mem[kp_q] <= data;
		pk_rd_q <= (pk_we && kp_q == kp_d) ? data : pk_mem[kp_d];
	end

endmodule

// File: sv/pcbb_fifo.sv
// ----------------------------------------------------------------------------
// pcbb_fifo
// Short command queue between the front end and the emitter.
// ----------------------------------------------------------------------------
module pcbb_fifo import pcbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t               ent_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + FIFO_AW'(1);
			if (pop)
				rp_q <= rp_q + FIFO_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (FIFO_AW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (FIFO_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_cmd;
	end

endmodule

// File: sv/pcbb_back.sv
// ----------------------------------------------------------------------------
// pcbb_back
// Expands commands into output beats: varint headers, key and value bytes,
// and the restart trailer. Owns the restart offset table.
// ----------------------------------------------------------------------------
module pcbb_back import pcbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  cmd_t        head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_data,
	output logic [2:0]  out_bytes,
	output logic        last,
	output logic        block_end,
	output logic        overflow
);

	typedef enum logic [5:0] {
		BK_IDLE = 6'b000001,
		BK_VAR  = 6'b000010,
		BK_BYTE = 6'b000100,
		BK_FRD  = 6'b001000,
		BK_FOUT = 6'b010000,
		BK_CNT  = 6'b100000
	} bk_state_t;

	bk_state_t         st_q, st_d;
	cmd_t              cmd_q;
	logic              ld_cmd;
	logic [1:0]        fld_q, fld_d;
	logic [15:0]       v_q, v_d;
	logic [RST_AW-1:0] idx_q, idx_d;

	logic [31:0]       rs_mem [MAX_RESTARTS];
	logic [31:0]       rs_rd_q;

	logic              out_valid_q;
	logic [31:0]       out_data_q;
	logic [2:0]        out_bytes_q;
	logic              last_q, block_end_q, overflow_q;

	logic              free, emit;
	logic [31:0]       e_data;
	logic [2:0]        e_bytes;
	logic              e_last, e_end, e_ovf;

	assign free = ~out_valid_q | ~out_stall;

	always_comb begin
		st_d    = st_q;
		fld_d   = fld_q;
		v_d     = v_q;
		idx_d   = idx_q;
		pop     = 1'b0;
		ld_cmd  = 1'b0;
		emit    = 1'b0;
		e_data  = 32'd0;
		e_bytes = 3'd1;
		e_last  = 1'b0;
		e_end   = 1'b0;
		e_ovf   = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (!empty) begin
					if (head.kind == CMD_BYTE) begin
						if (free) begin
							pop    = 1'b1;
							emit   = 1'b1;
							e_data = {24'd0, head.data};
							e_last = 1'b1;
						end
					end else if (head.kind == CMD_HDR) begin
						pop    = 1'b1;
						ld_cmd = 1'b1;
						st_d   = BK_VAR;
						fld_d  = 2'd0;
						v_d    = 16'(head.shared_len);
					end else begin
						pop    = 1'b1;
						ld_cmd = 1'b1;
						st_d   = BK_FRD;
						idx_d  = '0;
					end
				end
			end
			BK_VAR: begin
				if (free) begin
					emit  = 1'b1;
					e_ovf = cmd_q.ovf;
					if (v_q >= 16'd128) begin
						e_data = {24'd0, 1'b1, v_q[6:0]};
						v_d    = v_q >> 7;
					end else begin
						e_data = {24'd0, v_q[7:0]};
						case (fld_q)
							2'd0: begin
								fld_d = 2'd1;
								v_d   = 16'(cmd_q.unshared_len);
							end
							2'd1: begin
								fld_d = 2'd2;
								v_d   = cmd_q.value_len;
							end
							default: begin
								if (cmd_q.has_byte) begin
									st_d = BK_BYTE;
								end else begin
									st_d   = BK_IDLE;
									e_last = 1'b1;
								end
							end
						endcase
					end
				end
			end
			BK_BYTE: begin
				if (free) begin
					emit   = 1'b1;
					e_data = {24'd0, cmd_q.data};
					e_ovf  = cmd_q.ovf;
					e_last = 1'b1;
					st_d   = BK_IDLE;
				end
			end
			BK_FRD: begin
				st_d = BK_FOUT;
			end
			BK_FOUT: begin
				if (free) begin
					emit    = 1'b1;
					e_bytes = 3'd4;
					// restart point zero is always at offset zero
					e_data  = (idx_q == '0) ? 32'd0 : rs_rd_q;
					if (CNT_W'(idx_q) + CNT_W'(1) == cmd_q.cnt) begin
						st_d = BK_CNT;
					end else begin
						idx_d = idx_q + RST_AW'(1);
						st_d  = BK_FRD;
					end
				end
			end
			BK_CNT: begin
				if (free) begin
					emit    = 1'b1;
					e_bytes = 3'd4;
					e_data  = 32'(cmd_q.cnt);
					e_last  = 1'b1;
					e_end   = 1'b1;
					st_d    = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_cmd)
			cmd_q <= head;
		fld_q <= fld_d;
		v_q   <= v_d;
		idx_q <= idx_d;
		if (emit) begin
			out_data_q  <= e_data;
			out_bytes_q <= e_bytes;
			last_q      <= e_last;
			block_end_q <= e_end;
			overflow_q  <= e_ovf;
		end
	end

	// restart table: record on header pop; at finish each entry is read in BK_FRD before BK_FOUT sends it
	always_ff @(posedge clk) begin
		if (ld_cmd && head.rst_we)
			rs_mem[head.rst_idx] <= head.rst_off;
		rs_rd_q <= rs_mem[idx_q];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_bytes = out_bytes_q;
	assign last      = last_q;
	assign block_end = block_end_q;
	assign overflow  = overflow_q;

endmodule

// File: sv/prefix_compressed_block_builder_unit.sv
// Path: a plain byte goes through the command queue and then the output register; a header
// first loads the emitter's command register, and a finish also takes a BK_FRD read step.
// Throughput: the front takes one item a cycle while the 4-entry queue has room;
// while the output is not stalled, the emitter gives one beat a cycle for header and data
// bytes, plus a load step for each header or finish command, a BK_FRD read step and a
// BK_FOUT send step per restart offset word and a BK_CNT send step for the count word.
// Reset: control state clears at once; restart interval returns to 16.
// ----------------------------------------------------------------------------
// prefix_compressed_block_builder_unit
// Sorted key-value block builder with prefix-compressed keys and restart
// trailer, split into a classifying front end, a command queue and an emitter.
// ----------------------------------------------------------------------------
module prefix_compressed_block_builder_unit import pcbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  data,
	input  logic [8:0]  key_len,
	input  logic [15:0] value_len,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_data,
	output logic [2:0]  out_bytes,
	output logic        last,
	output logic        block_end,
	output logic        overflow
);

	logic push, full, pop, empty;
	cmd_t push_cmd, head;

	pcbb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.data        (data),
		.key_len     (key_len),
		.value_len   (value_len),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fifo_full   (full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	pcbb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	pcbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.out_bytes (out_bytes),
		.last      (last),
		.block_end (block_end),
		.overflow  (overflow)
	);

endmodule
